>>> rtl/core/tod_pkg.sv
// Shared types and constants for the tilt orientation debouncer.
package tod_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLED          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_GRAVITY      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DOMINANCE_MARGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_POLL_INTERVAL_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SETTLE_MS        = 3'd4;

  localparam logic [CFG_W-1:0] MIN_GRAVITY_RST      = 16'd10158;
  localparam logic [CFG_W-1:0] DOMINANCE_MARGIN_RST = 16'd1966;
  localparam logic [CFG_W-1:0] POLL_INTERVAL_RST    = 16'd100;
  localparam logic [CFG_W-1:0] SETTLE_RST           = 16'd500;

  typedef enum logic [1:0] {
    ROT_POS_X = 2'd0,
    ROT_POS_Y = 2'd1,
    ROT_NEG_X = 2'd2,
    ROT_NEG_Y = 2'd3
  } rot_e;

  typedef struct packed {
    logic             enabled;
    logic [CFG_W-1:0] min_gravity;
    logic [CFG_W-1:0] dominance_margin;
    logic [CFG_W-1:0] poll_interval_ms;
    logic [CFG_W-1:0] settle_ms;
  } cfg_t;

  typedef struct packed {
    logic sample_valid;
    logic accept;
    rot_e rot;
  } cls_t;

endpackage

>>> rtl/core/tilt_orientation_debouncer_unit.sv
// Top level of the tilt orientation debouncer.
//
//   channel | handshake                  | payload
//   in      | in_valid_i / in_ready_o    | time_ms_i, sample_valid_i, accel_x_i, accel_y_i
//   out     | out_valid_o / out_ready_i  | rotation_changed_o, rotation_o
//   cfg     | cfg_we_i                   | cfg_index_i, cfg_wdata_i
//
// One request per cycle sustained while the output is not stalled.
// The classifier writes a two-entry queue; the debouncer drains one entry per cycle
// into the result register whenever that register is empty or being taken.
// Reset clears the debounce state and loads the register defaults.
// A stalled output holds the debouncer; the queue then fills and drops in_ready_o.
module tilt_orientation_debouncer_unit import tod_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [TIME_BITS-1:0]   time_ms_i,
  input  logic                   sample_valid_i,
  input  logic [SAMPLE_BITS-1:0] accel_x_i,
  input  logic [SAMPLE_BITS-1:0] accel_y_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   rotation_changed_o,
  output logic [1:0]             rotation_o
);

  localparam int unsigned CLS_W   = $bits(cls_t);
  localparam int unsigned ENTRY_W = TIME_BITS + CLS_W;

  cfg_t                 cfg_q;
  cls_t                 front_cls, back_cls;
  logic                 q_push, q_full, q_pop, q_empty;
  logic [ENTRY_W-1:0]   q_wdata, q_rdata;
  logic [TIME_BITS-1:0] back_time;
  rot_e                 rot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled          <= 1'b0;
      cfg_q.min_gravity      <= MIN_GRAVITY_RST;
      cfg_q.dominance_margin <= DOMINANCE_MARGIN_RST;
      cfg_q.poll_interval_ms <= POLL_INTERVAL_RST;
      cfg_q.settle_ms        <= SETTLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IDX_ENABLED:          cfg_q.enabled          <= cfg_wdata_i[0];
        CFG_IDX_MIN_GRAVITY:      cfg_q.min_gravity      <= cfg_wdata_i;
        CFG_IDX_DOMINANCE_MARGIN: cfg_q.dominance_margin <= cfg_wdata_i;
        CFG_IDX_POLL_INTERVAL_MS: cfg_q.poll_interval_ms <= cfg_wdata_i;
        CFG_IDX_SETTLE_MS:        cfg_q.settle_ms        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tod_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_valid_i(sample_valid_i),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .cfg_i         (cfg_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .cls_o         (front_cls)
  );

  assign q_wdata = {time_ms_i, front_cls};

  tod_queue #(
    .DATA_W(ENTRY_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_rdata)
  );

  assign back_time = q_rdata[ENTRY_W-1 -: TIME_BITS];
  assign back_cls  = cls_t'(q_rdata[CLS_W-1:0]);

  tod_back #(
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .time_i     (back_time),
    .cls_i      (back_cls),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .changed_o  (rotation_changed_o),
    .rotation_o (rot)
  );

  assign rotation_o = 2'(rot);

endmodule

>>> rtl/core/tod_front.sv
// Front end: request intake and dominant-axis classification.
module tod_front import tod_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   sample_valid_i,
  input  logic [SAMPLE_BITS-1:0] accel_x_i,
  input  logic [SAMPLE_BITS-1:0] accel_y_i,
  input  cfg_t                   cfg_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output cls_t                   cls_o
);

  localparam int unsigned MAG_W = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;

  logic                   x_neg, y_neg, x_gt;
  logic [SAMPLE_BITS-1:0] ax, ay, dom, sec, diff;

  assign x_neg = accel_x_i[SAMPLE_BITS-1];
  assign y_neg = accel_y_i[SAMPLE_BITS-1];
  assign ax    = x_neg ? (~accel_x_i + 1'b1) : accel_x_i;
  assign ay    = y_neg ? (~accel_y_i + 1'b1) : accel_y_i;
  assign x_gt  = ax > ay;
  assign dom   = x_gt ? ax : ay;
  assign sec   = x_gt ? ay : ax;
  assign diff  = dom - sec;

  always_comb begin
    cls_o.sample_valid = sample_valid_i;
    cls_o.accept = (MAG_W'(dom) >= MAG_W'(cfg_i.min_gravity)) &&
                   (MAG_W'(diff) >= MAG_W'(cfg_i.dominance_margin));
    if (x_gt) begin
      cls_o.rot = x_neg ? ROT_NEG_X : ROT_POS_X;
    end else begin
      cls_o.rot = (!y_neg && (ay != '0)) ? ROT_POS_Y : ROT_NEG_Y;
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

>>> rtl/core/tod_queue.sv
// Two-entry queue between the classifier and the debouncer.
module tod_queue #(
  parameter int unsigned DATA_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/tod_back.sv
// Back end: rate gate, debounce state and result register.
module tod_back import tod_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 q_empty_i,
  input  logic [TIME_BITS-1:0] time_i,
  input  cls_t                 cls_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 changed_o,
  output rot_e                 rotation_o
);

  rot_e                 cur_q, cur_d, pend_q, pend_d;
  logic                 pv_q, pv_d;
  logic [TIME_BITS-1:0] since_q, since_d, nst_q, nst_d;
  logic                 out_valid_q, out_valid_d, changed_q, changed_d;
  logic [TIME_BITS-1:0] elapsed, held;
  logic                 gate, chg;

  assign q_pop_o = !q_empty_i && (!out_valid_q || out_ready_i);
  assign elapsed = time_i - nst_q;
  assign held    = time_i - since_q;
  assign gate    = cfg_i.enabled && !elapsed[TIME_BITS-1];

  always_comb begin
    cur_d   = cur_q;
    pend_d  = pend_q;
    pv_d    = pv_q;
    since_d = since_q;
    nst_d   = nst_q;
    chg     = 1'b0;
    if (q_pop_o && gate) begin
      nst_d = time_i + TIME_BITS'(cfg_i.poll_interval_ms);
      if (cls_i.sample_valid) begin
        if (!cls_i.accept) begin
          pv_d = 1'b0;
        end else if (!pv_q || (cls_i.rot != pend_q)) begin
          pend_d  = cls_i.rot;
          since_d = time_i;
          pv_d    = 1'b1;
        end else if ((pend_q != cur_q) && (held >= TIME_BITS'(cfg_i.settle_ms))) begin
          cur_d = pend_q;
          chg   = 1'b1;
        end
      end
    end
    out_valid_d = out_valid_q;
    changed_d   = changed_q;
    if (q_pop_o) begin
      out_valid_d = 1'b1;
      changed_d   = chg;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= ROT_POS_X;
      pend_q      <= ROT_POS_X;
      pv_q        <= 1'b0;
      since_q     <= '0;
      nst_q       <= '0;
      out_valid_q <= 1'b0;
      changed_q   <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      pend_q      <= pend_d;
      pv_q        <= pv_d;
      since_q     <= since_d;
      nst_q       <= nst_d;
      out_valid_q <= out_valid_d;
      changed_q   <= changed_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign changed_o   = changed_q;
  assign rotation_o  = cur_q;

endmodule

>>> verif/tod_rotation_checker.sv
// Scoreboard for the tilt orientation debouncer: mirrors the debounce state and compares results.
module tod_rotation_checker import tod_pkg::*; #(
  parameter int unsigned SAMPLE_W = 16,
  parameter int unsigned TIME_W   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [TIME_W-1:0]   time_ms_i,
  input  logic                sample_valid_i,
  input  logic [SAMPLE_W-1:0] accel_x_i,
  input  logic [SAMPLE_W-1:0] accel_y_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                rotation_changed_i,
  input  logic [1:0]          rotation_i,
  output int                  outstanding_o,
  output int                  fail_count_o,
  output int                  changes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic changed;
    rot_e rot;
  } rot_report_t;

  cfg_t              regs;
  rot_e              cur_rot;
  rot_e              cand_rot;
  logic              cand_valid;
  logic [TIME_W-1:0] cand_since;
  logic [TIME_W-1:0] next_poll;

  rot_report_t rot_expect_q[$];
  int          fail_cnt;
  int          change_cnt;
  int          results_seen;

  assign fail_count_o = fail_cnt;
  assign changes_o    = change_cnt;

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  function automatic rot_report_t debounce_poll(input logic [TIME_W-1:0] now,
                                                input logic sv,
                                                input logic [SAMPLE_W-1:0] ax,
                                                input logic [SAMPLE_W-1:0] ay);
    rot_report_t       res;
    logic [TIME_W-1:0] since_poll;
    logic [SAMPLE_W:0] mag_x, mag_y, dom, sec;
    logic              neg_x, neg_y, usable;
    rot_e              cand;
    res.changed = 1'b0;
    since_poll  = now - next_poll;
    if (regs.enabled && !since_poll[TIME_W-1]) begin
      next_poll = now + TIME_W'(regs.poll_interval_ms);
      if (sv) begin
        neg_x  = ax[SAMPLE_W-1];
        neg_y  = ay[SAMPLE_W-1];
        mag_x  = neg_x ? ({1'b1, {SAMPLE_W{1'b0}}} - {1'b0, ax}) : {1'b0, ax};
        mag_y  = neg_y ? ({1'b1, {SAMPLE_W{1'b0}}} - {1'b0, ay}) : {1'b0, ay};
        dom    = (mag_x > mag_y) ? mag_x : mag_y;
        sec    = (mag_x > mag_y) ? mag_y : mag_x;
        usable = (dom >= {1'b0, regs.min_gravity}) &&
                 ((dom - sec) >= {1'b0, regs.dominance_margin});
        // ties go to Y; a zero on the winning axis reads as negative
        if (mag_x > mag_y) begin
          cand = (!neg_x && mag_x != '0) ? ROT_POS_X : ROT_NEG_X;
        end else begin
          cand = (!neg_y && mag_y != '0) ? ROT_POS_Y : ROT_NEG_Y;
        end
        if (!usable) begin
          cand_valid = 1'b0;
        end else if (!cand_valid || cand != cand_rot) begin
          cand_rot   = cand;
          cand_since = now;
          cand_valid = 1'b1;
        end else if (cand_rot != cur_rot &&
                     (now - cand_since) >= TIME_W'(regs.settle_ms)) begin
          cur_rot     = cand_rot;
          res.changed = 1'b1;
        end
      end
    end
    res.rot = cur_rot;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rot_report_t want;
    if (!rst_ni) begin
      regs.enabled          = 1'b0;
      regs.min_gravity      = MIN_GRAVITY_RST;
      regs.dominance_margin = DOMINANCE_MARGIN_RST;
      regs.poll_interval_ms = POLL_INTERVAL_RST;
      regs.settle_ms        = SETTLE_RST;
      cur_rot    = ROT_POS_X;
      cand_rot   = ROT_POS_X;
      cand_valid = 1'b0;
      cand_since = '0;
      next_poll  = '0;
      rot_expect_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_IDX_ENABLED:          regs.enabled          = cfg_wdata_i[0];
          CFG_IDX_MIN_GRAVITY:      regs.min_gravity      = cfg_wdata_i;
          CFG_IDX_DOMINANCE_MARGIN: regs.dominance_margin = cfg_wdata_i;
          CFG_IDX_POLL_INTERVAL_MS: regs.poll_interval_ms = cfg_wdata_i;
          CFG_IDX_SETTLE_MS:        regs.settle_ms        = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (rot_expect_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with no request pending", results_seen));
        end else begin
          want = rot_expect_q.pop_front();
          if (rotation_changed_i !== want.changed) begin
            flag_mismatch($sformatf("result %0d rotation_changed %b, want %b",
                                    results_seen, rotation_changed_i, want.changed));
          end
          if (rotation_i !== want.rot) begin
            flag_mismatch($sformatf("result %0d rotation %0d, want %0d",
                                    results_seen, rotation_i, want.rot));
          end
          if (want.changed) change_cnt++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        rot_expect_q.push_back(debounce_poll(time_ms_i, sample_valid_i, accel_x_i, accel_y_i));
      end
      outstanding_o <= rot_expect_q.size();
    end
  end

endmodule

>>> verif/tilt_orientation_debouncer_unit_tb.sv
// Testbench top for the tilt orientation debouncer: clock, reset, stimulus and verdict.
module tilt_orientation_debouncer_unit_tb import tod_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_W         = 16;
  localparam int unsigned TIME_W           = 32;
  localparam int          PHASES           = 8;
  localparam int          PHASE_POLLS      = 180;
  localparam int          PRESSURE_POLLS   = 50;
  localparam int          LONG_HOLD_CYCLES = 300;

  localparam logic [SAMPLE_W-1:0] G_POS    = 16'h4000;
  localparam logic [SAMPLE_W-1:0] G_NEG    = 16'hC000;
  localparam logic [SAMPLE_W-1:0] FULL_POS = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] FULL_NEG = 16'h8000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [TIME_W-1:0]    time_ms_i;
  logic                 sample_valid_i;
  logic [SAMPLE_W-1:0]  accel_x_i;
  logic [SAMPLE_W-1:0]  accel_y_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 rotation_changed_o;
  logic [1:0]           rotation_o;

  int outstanding;
  int fail_count;
  int changes;

  cfg_t              live_cfg;
  logic [TIME_W-1:0] stamp_ms;
  rot_e              aim_rot;
  int                run_left;
  int                polls_sent;
  int                settings_used;
  bit                steady_flow;
  int                long_holds_req;
  int                long_holds_done;

  tilt_orientation_debouncer_unit #(
    .SAMPLE_BITS(SAMPLE_W),
    .TIME_BITS  (TIME_W)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .time_ms_i         (time_ms_i),
    .sample_valid_i    (sample_valid_i),
    .accel_x_i         (accel_x_i),
    .accel_y_i         (accel_y_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .rotation_changed_o(rotation_changed_o),
    .rotation_o        (rotation_o)
  );

  tod_rotation_checker #(
    .SAMPLE_W(SAMPLE_W),
    .TIME_W  (TIME_W)
  ) rotation_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .time_ms_i         (time_ms_i),
    .sample_valid_i    (sample_valid_i),
    .accel_x_i         (accel_x_i),
    .accel_y_i         (accel_y_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .rotation_changed_i(rotation_changed_o),
    .rotation_i        (rotation_o),
    .outstanding_o     (outstanding),
    .fail_count_o      (fail_count),
    .changes_o         (changes)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("** tilt_orientation_debouncer_unit: FAILED **");
    $finish;
  end

  function automatic int unsigned idle_len(input bit allow_zero);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cfg_t make_cfg(input bit en, input int unsigned min_g,
                                    input int unsigned margin, input int unsigned poll,
                                    input int unsigned settle);
    cfg_t c;
    c.enabled          = en;
    c.min_gravity      = CFG_W'(min_g);
    c.dominance_margin = CFG_W'(margin);
    c.poll_interval_ms = CFG_W'(poll);
    c.settle_ms        = CFG_W'(settle);
    return c;
  endfunction

  task automatic send_poll(input logic [TIME_W-1:0] t, input logic sv,
                           input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y);
    int unsigned gap;
    in_valid_i     <= 1'b1;
    time_ms_i      <= t;
    sample_valid_i <= sv;
    accel_x_i      <= x;
    accel_y_i      <= y;
    do @(posedge clk_i); while (!in_ready_o);
    polls_sent++;
    gap = steady_flow ? 0 : idle_len(1'b1);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic apply_settings(input cfg_t s);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_IDX_ENABLED;
    cfg_wdata_i <= CFG_W'({$urandom_range(0, 32767), s.enabled});
    @(posedge clk_i);
    cfg_index_i <= CFG_IDX_MIN_GRAVITY;
    cfg_wdata_i <= s.min_gravity;
    @(posedge clk_i);
    cfg_index_i <= CFG_IDX_DOMINANCE_MARGIN;
    cfg_wdata_i <= s.dominance_margin;
    @(posedge clk_i);
    cfg_index_i <= CFG_IDX_POLL_INTERVAL_MS;
    cfg_wdata_i <= s.poll_interval_ms;
    @(posedge clk_i);
    cfg_index_i <= CFG_IDX_SETTLE_MS;
    cfg_wdata_i <= s.settle_ms;
    @(posedge clk_i);
    for (int idx = int'(CFG_IDX_SETTLE_MS) + 1; idx < (1 << CFG_IDX_W); idx++) begin
      cfg_index_i <= CFG_IDX_W'(idx);
      cfg_wdata_i <= CFG_W'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    live_cfg = s;
    settings_used++;
  endtask

  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_holds_done < long_holds_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_holds_done++;
      end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat (idle_len(1'b0)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    cfg_t                s;
    int unsigned         sel, mag, side;
    logic [TIME_W-1:0]   t;
    logic                sv;
    logic [SAMPLE_W-1:0] x, y, main_v, side_v;

    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= CFG_IDX_ENABLED;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    time_ms_i      <= '0;
    sample_valid_i <= 1'b0;
    accel_x_i      <= '0;
    accel_y_i      <= '0;
    run_left       = 0;
    aim_rot        = ROT_POS_X;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // out of reset the block is disabled
    send_poll(32'd0, 1'b1, G_POS, 16'h0000);
    send_poll(32'd700, 1'b1, 16'h0000, G_NEG);
    drain();
    apply_settings(make_cfg(1'b1, MIN_GRAVITY_RST, DOMINANCE_MARGIN_RST,
                            POLL_INTERVAL_RST, SETTLE_RST));
    send_poll(32'd0, 1'b1, G_POS, 16'h0000);
    send_poll(32'd50, 1'b1, 16'h0000, G_POS);
    send_poll(32'h9000_0000, 1'b1, 16'h0000, G_POS);
    send_poll(32'd100, 1'b1, 16'h0000, G_POS);
    send_poll(32'd200, 1'b1, 16'h0000, G_POS);
    send_poll(32'd600, 1'b1, 16'h0000, G_POS);
    send_poll(32'd700, 1'b0, G_NEG, 16'h0000);
    send_poll(32'd800, 1'b1, G_NEG, 16'h0000);
    send_poll(32'd900, 1'b1, 16'd100, 16'd50);
    send_poll(32'd1000, 1'b1, G_NEG, 16'h0000);
    send_poll(32'd1499, 1'b1, G_NEG, 16'h0000);
    send_poll(32'd1599, 1'b1, G_NEG, 16'h0000);
    send_poll(32'd1700, 1'b1, 16'd16000, 16'hC568);
    send_poll(32'd1800, 1'b1, FULL_POS, FULL_NEG);
    send_poll(32'd1900, 1'b1, 16'h0000, FULL_NEG);
    send_poll(32'h7FFF_FF00, 1'b1, 16'h0000, FULL_NEG);
    send_poll(32'hFFFF_FF00, 1'b1, FULL_POS, 16'h0000);
    send_poll(32'h0000_0020, 1'b1, FULL_POS, 16'h0000);
    send_poll(32'h0000_0100, 1'b1, FULL_POS, 16'h0000);
    drain();
    apply_settings(make_cfg(1'b1, 0, 0, 0, 0));
    send_poll(32'h0000_0200, 1'b1, 16'h0000, 16'h0000);
    send_poll(32'h0000_0200, 1'b1, 16'h0000, 16'h0000);
    send_poll(32'h0000_0201, 1'b1, 16'hB1E0, 16'h4E20);
    send_poll(32'h0000_0201, 1'b1, 16'hB1E0, 16'h4E20);
    stamp_ms = 32'h0000_0201;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: s = make_cfg(1'b1, MIN_GRAVITY_RST, DOMINANCE_MARGIN_RST,
                        POLL_INTERVAL_RST, SETTLE_RST);
        1: s = make_cfg(1'b1, 0, 0, 0, 0);
        2: s = make_cfg(1'b1, 32768, 32768, 65535, 65535);
        3: s = make_cfg(1'b0, $urandom_range(0, 20000), $urandom_range(0, 8000),
                        $urandom_range(0, 300), $urandom_range(0, 2000));
        default: s = make_cfg(1'b1, $urandom_range(0, 20000), $urandom_range(0, 8000),
                              $urandom_range(0, 300),
                              ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 2000));
      endcase
      drain();
      apply_settings(s);
      if (p == 0) long_holds_req++;
      for (int i = 0; i < PHASE_POLLS; i++) begin
        steady_flow = (p < 2) && (i < PRESSURE_POLLS);

        sel = $urandom_range(0, 99);
        if (sel < 4) begin
          t = stamp_ms - $urandom_range(1, 32'h4000_0000);
        end else begin
          if (sel < 8) begin
            stamp_ms += $urandom_range(0, 32'h00FF_FFFF);
          end else if (sel < 15) begin
            stamp_ms += $urandom_range(0, live_cfg.poll_interval_ms);
          end else begin
            stamp_ms += live_cfg.poll_interval_ms + $urandom_range(0, 40) +
                        ((sel < 35) ? $urandom_range(0, live_cfg.settle_ms) : 0);
          end
          t = stamp_ms;
        end

        if (run_left == 0) begin
          aim_rot  = rot_e'($urandom_range(0, 3));
          run_left = $urandom_range(2, 10);
        end
        run_left--;
        sel = $urandom_range(0, 99);
        sv  = 1'b1;
        x   = SAMPLE_W'($urandom);
        y   = SAMPLE_W'($urandom);
        if (sel < 8) begin
          sv = 1'b0;
        end else if (sel >= 14) begin
          if (sel < 19) begin
            mag = (live_cfg.min_gravity == 0) ? 0 :
                  $urandom_range(0, live_cfg.min_gravity - 1);
          end else begin
            mag = live_cfg.min_gravity + $urandom_range(0, 4000);
          end
          if (mag > 32768) mag = 32768;
          if (sel < 24) begin
            side = (mag > live_cfg.dominance_margin) ?
                   mag - $urandom_range(0, live_cfg.dominance_margin) : $urandom_range(0, mag);
          end else begin
            side = (mag >= live_cfg.dominance_margin) ?
                   $urandom_range(0, mag - live_cfg.dominance_margin) : 0;
          end
          main_v = (aim_rot == ROT_POS_X || aim_rot == ROT_POS_Y) ?
                   SAMPLE_W'((mag > 32767) ? 32767 : mag) : SAMPLE_W'(-int'(mag));
          side_v = $urandom_range(0, 1) ? SAMPLE_W'(side) : SAMPLE_W'(-int'(side));
          if (aim_rot == ROT_POS_X || aim_rot == ROT_NEG_X) begin
            x = main_v;
            y = side_v;
          end else begin
            x = side_v;
            y = main_v;
          end
        end
        send_poll(t, sv, x, y);
      end
      steady_flow = 1'b0;
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Run: %0d polls under %0d register settings, %0d rotation changes reported,",
             polls_sent, settings_used, changes);
    $display("one %0d-cycle output hold-off with back-to-back requests.", LONG_HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("** tilt_orientation_debouncer_unit: PASSED **");
    end else begin
      $display("** tilt_orientation_debouncer_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> tilt_orientation_debouncer_unit.f
rtl/core/tod_pkg.sv
rtl/core/tod_front.sv
rtl/core/tod_queue.sv
rtl/core/tod_back.sv
rtl/core/tilt_orientation_debouncer_unit.sv
verif/tod_rotation_checker.sv
verif/tilt_orientation_debouncer_unit_tb.sv
